### sv/gwm_pkg.sv
// Shared types and constants for the glob wildcard matcher.
`default_nettype none

package gwm_pkg;

   // Request codes on req_type
   localparam logic [1:0] REQ_PATTERN_BYTE = 2'd0;
   localparam logic [1:0] REQ_PATTERN_END  = 2'd1;
   localparam logic [1:0] REQ_TEXT_BYTE    = 2'd2;
   localparam logic [1:0] REQ_TEXT_END     = 2'd3;

   // Pattern metacharacters
   localparam logic [7:0] CHAR_ANY   = 8'h3F;  // '?'
   localparam logic [7:0] CHAR_STAR  = 8'h2A;  // '*'
   localparam logic [7:0] CHAR_OPEN  = 8'h5B;  // '['
   localparam logic [7:0] CHAR_CLOSE = 8'h5D;  // ']'
   localparam logic [7:0] CHAR_ESC   = 8'h5C;  // backslash

   // ASCII case folding bounds
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_CLS  = 4'b0010,
      ST_SCAN = 4'b0100,
      ST_MEMB = 4'b1000
   } state_type;

   typedef struct packed {
      logic eq_exact;
      logic eq_fold;
   } cmp_result_type;

endpackage

`default_nettype wire

### sv/gwm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module gwm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### sv/gwm_cmp.sv
// Shared byte comparator: exact and case-folded equality.
`default_nettype none

module gwm_cmp (
   input  wire logic [7:0]          lhs,
   input  wire logic [7:0]          rhs,
   input  wire logic                fold_en,
   output gwm_pkg::cmp_result_type  result
);

   logic [7:0] lhs_fold;
   logic [7:0] rhs_fold;

   // Fold only 'A'..'Z'; everything else passes through
   always_comb begin
      lhs_fold = lhs;
      rhs_fold = rhs;
      if (fold_en && lhs >= gwm_pkg::CHAR_UPPER_A && lhs <= gwm_pkg::CHAR_UPPER_Z) begin
         lhs_fold = lhs + gwm_pkg::CASE_OFFSET;
      end
      if (fold_en && rhs >= gwm_pkg::CHAR_UPPER_A && rhs <= gwm_pkg::CHAR_UPPER_Z) begin
         rhs_fold = rhs + gwm_pkg::CASE_OFFSET;
      end
      result.eq_exact = (lhs == rhs);
      result.eq_fold  = (lhs_fold == rhs_fold);
   end

endmodule

`default_nettype wire

### sv/glob_wildcard_matcher.sv
// Top level of the glob wildcard matcher: sequencer, pattern and class stores.
//
// Usage:
//   Requests are taken when start is high and busy is low. req_type selects
//   pattern byte, pattern end, text byte or text end; req_char_byte carries
//   the byte. Load a pattern byte by byte, seal it with a pattern end, then
//   stream text bytes; a text end returns one result on rsp_matched and
//   rsp_pattern_overflow, marked by rsp_strobe for one cycle, in the cycle
//   after the transfer. The receiver cannot stall; take the result then.
//   Text items before the first pattern end are dropped without a result.
// Work per request:
//   pattern byte: stored while the block stays idle.
//   text byte: one comparator walks every pattern position, and every
//   member of each active class, one per cycle.
//   pattern end: backward class walk, then rearm walk.
//   text end: result, then rearm walk.
// The user writes csr_case_insensitive through csr_valid/csr_ready while idle;
// the block does not enforce this. Reset clears the length, overflow flag, case mode
// and automaton state; the pattern and class stores hold garbage until written.
`default_nettype none

module glob_wildcard_matcher #(
   parameter int PATTERN_MAX = 64
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire logic [1:0] req_type,
   input  wire logic [7:0] req_char_byte,
   output logic            rsp_strobe,
   output logic            rsp_matched,
   output logic            rsp_pattern_overflow,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic       csr_case_insensitive
);

   localparam int AW = $clog2(PATTERN_MAX);       // store address width
   localparam int PW = $clog2(PATTERN_MAX + 1);   // position / length width
   localparam logic [PATTERN_MAX:0] ActInit = {{PATTERN_MAX{1'b0}}, 1'b1};

   gwm_pkg::state_type state_ff, state_in;

   logic [PW-1:0]          len_ff, len_in;
   logic                   ovf_ff, ovf_in;
   logic                   sealed_ff, sealed_in;
   logic                   case_ff, case_in;
   logic [PATTERN_MAX:0]   act_ff, act_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;

   logic [PATTERN_MAX:0]   nxt_ff, nxt_in;
   logic [AW-1:0]          p_ff, p_in;
   logic [AW-1:0]          m_ff, m_in;
   logic [AW-1:0]          q_ff, q_in;
   logic [AW-1:0]          near_ff, near_in;
   logic                   have_ff, have_in;
   logic                   hit_ff, hit_in;
   logic                   esc_ff, esc_in;
   logic                   adv_ff, adv_in;
   logic [7:0]             c_ff, c_in;
   logic                   rsp_matched_ff, rsp_matched_in;
   logic                   rsp_ovf_ff, rsp_ovf_in;

   // Store ports
   logic                   pat_we;
   logic [AW-1:0]          pat_waddr;
   logic [7:0]             pat_wdata;
   logic [7:0]             pat_rdata;
   logic                   cls_we;
   logic [AW-1:0]          cls_wdata;
   logic [AW-1:0]          cls_rdata;
   logic [AW-1:0]          rd_addr;

   gwm_pkg::cmp_result_type cmp;

   // Sequencer scratch
   logic                   accept;
   logic                   launch;
   logic                   launch_adv;
   logic                   enter_memb;
   logic                   esc_nx;
   logic                   hit_now;
   logic [PW-1:0]          base;
   logic [PW-1:0]          p0;
   logic [PW-1:0]          p1;
   logic [PATTERN_MAX:0]   n_vec;

   gwm_ram #(.WIDTH(8), .DEPTH(PATTERN_MAX)) u_pat_ram (
      .clock   (clock),
      .wr_en   (pat_we),
      .wr_addr (pat_waddr),
      .wr_data (pat_wdata),
      .rd_addr (rd_addr),
      .rd_data (pat_rdata)
   );

   // Class store: for each '[', index of its closing ']' or itself
   gwm_ram #(.WIDTH(AW), .DEPTH(PATTERN_MAX)) u_cls_ram (
      .clock   (clock),
      .wr_en   (cls_we),
      .wr_addr (p_ff),
      .wr_data (cls_wdata),
      .rd_addr (rd_addr),
      .rd_data (cls_rdata)
   );

   // The one comparator: stored byte against the current text byte
   gwm_cmp u_cmp (
      .lhs     (pat_rdata),
      .rhs     (c_ff),
      .fold_en (case_ff),
      .result  (cmp)
   );

   assign busy                 = (state_ff != gwm_pkg::ST_IDLE);
   assign csr_ready            = 1'b1;
   assign accept               = start && (state_ff == gwm_pkg::ST_IDLE);
   assign rsp_strobe           = rsp_strobe_ff;
   assign rsp_matched          = rsp_matched_ff;
   assign rsp_pattern_overflow = rsp_ovf_ff;
   assign p0                   = PW'(p_ff);
   assign p1                   = PW'(p_ff) + PW'(1);

   always_comb begin
      state_in       = state_ff;
      len_in         = len_ff;
      ovf_in         = ovf_ff;
      sealed_in      = sealed_ff;
      case_in        = case_ff;
      act_in         = act_ff;
      rsp_strobe_in  = 1'b0;
      nxt_in         = nxt_ff;
      p_in           = p_ff;
      m_in           = m_ff;
      q_in           = q_ff;
      near_in        = near_ff;
      have_in        = have_ff;
      hit_in         = hit_ff;
      esc_in         = esc_ff;
      adv_in         = adv_ff;
      c_in           = c_ff;
      rsp_matched_in = rsp_matched_ff;
      rsp_ovf_in     = rsp_ovf_ff;
      pat_we         = 1'b0;
      pat_waddr      = '0;
      pat_wdata      = req_char_byte;
      cls_we         = 1'b0;
      cls_wdata      = p_ff;
      rd_addr        = '0;
      launch         = 1'b0;
      launch_adv     = 1'b0;
      enter_memb     = 1'b0;
      esc_nx         = 1'b0;
      hit_now        = hit_ff | cmp.eq_fold;
      base           = sealed_ff ? '0 : len_ff;
      n_vec          = nxt_ff;

      if (csr_valid) begin
         case_in = csr_case_insensitive;
      end

      case (state_ff)
         gwm_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_type)
                  gwm_pkg::REQ_PATTERN_BYTE: begin
                     // A byte after a seal starts a new pattern
                     if (sealed_ff) begin
                        sealed_in = 1'b0;
                        ovf_in    = 1'b0;
                     end
                     if (base < PW'(PATTERN_MAX)) begin
                        pat_we    = 1'b1;
                        pat_waddr = AW'(base);
                        len_in    = base + PW'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  gwm_pkg::REQ_PATTERN_END: begin
                     sealed_in = 1'b1;
                     if (len_ff == '0) begin
                        act_in = ActInit;
                     end else begin
                        // Walk the pattern backward to pair brackets
                        rd_addr  = AW'(len_ff - PW'(1));
                        p_in     = AW'(len_ff - PW'(1));
                        have_in  = 1'b0;
                        state_in = gwm_pkg::ST_CLS;
                     end
                  end
                  gwm_pkg::REQ_TEXT_BYTE: begin
                     if (sealed_ff) begin
                        c_in       = req_char_byte;
                        launch     = 1'b1;
                        launch_adv = 1'b1;
                     end
                  end
                  gwm_pkg::REQ_TEXT_END: begin
                     if (sealed_ff) begin
                        rsp_strobe_in  = 1'b1;
                        rsp_matched_in = !ovf_ff && act_ff[len_ff];
                        rsp_ovf_in     = ovf_ff;
                        launch         = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         gwm_pkg::ST_CLS: begin
            if (pat_rdata == gwm_pkg::CHAR_OPEN) begin
               cls_we    = 1'b1;
               cls_wdata = have_ff ? near_ff : p_ff;
            end
            if (pat_rdata == gwm_pkg::CHAR_CLOSE) begin
               near_in = p_ff;
               have_in = 1'b1;
            end
            if (p_ff == '0) begin
               launch = 1'b1;
            end else begin
               p_in    = p_ff - AW'(1);
               rd_addr = p_ff - AW'(1);
            end
         end

         gwm_pkg::ST_SCAN: begin
            // Escaped byte pending from the previous position
            if (adv_ff && esc_ff && cmp.eq_exact) begin
               n_vec[p1] = 1'b1;
            end
            if (adv_ff && act_ff[p0]) begin
               if (pat_rdata == gwm_pkg::CHAR_STAR) begin
                  n_vec[p0] = 1'b1;
               end else if (pat_rdata == gwm_pkg::CHAR_ANY) begin
                  n_vec[p1] = 1'b1;
               end else if (pat_rdata == gwm_pkg::CHAR_OPEN && PW'(cls_rdata) > p0 &&
                            PW'(cls_rdata) < len_ff) begin
                  // Walk members only when the class is not empty
                  if (PW'(cls_rdata) > p1) begin
                     enter_memb = 1'b1;
                  end
               end else if (pat_rdata == gwm_pkg::CHAR_ESC) begin
                  esc_nx = 1'b1;
               end else if (cmp.eq_fold) begin
                  n_vec[p1] = 1'b1;
               end
            end
            // Position p is final here: close a star over it
            if (n_vec[p0] && pat_rdata == gwm_pkg::CHAR_STAR) begin
               n_vec[p1] = 1'b1;
            end
            esc_in = esc_nx;
            if (p1 == len_ff) begin
               act_in   = n_vec;
               state_in = gwm_pkg::ST_IDLE;
            end else begin
               nxt_in  = n_vec;
               p_in    = p_ff + AW'(1);
               rd_addr = p_ff + AW'(1);
               if (enter_memb) begin
                  q_in     = cls_rdata;
                  m_in     = p_ff + AW'(1);
                  hit_in   = 1'b0;
                  state_in = gwm_pkg::ST_MEMB;
               end
            end
         end

         gwm_pkg::ST_MEMB: begin
            if (m_ff + AW'(1) == q_ff) begin
               if (hit_now) begin
                  nxt_in[PW'(q_ff) + PW'(1)] = 1'b1;
               end
               // Resume the main walk at the position after the '['
               rd_addr  = p_ff;
               state_in = gwm_pkg::ST_SCAN;
            end else begin
               hit_in  = hit_now;
               m_in    = m_ff + AW'(1);
               rd_addr = m_ff + AW'(1);
            end
         end

         default: begin
            state_in = gwm_pkg::ST_IDLE;
         end
      endcase

      // Start a position walk: advance on a text byte, rearm otherwise
      if (launch) begin
         if (len_ff == '0) begin
            act_in   = launch_adv ? '0 : ActInit;
            state_in = gwm_pkg::ST_IDLE;
         end else begin
            rd_addr  = '0;
            p_in     = '0;
            esc_in   = 1'b0;
            adv_in   = launch_adv;
            nxt_in   = launch_adv ? '0 : ActInit;
            state_in = gwm_pkg::ST_SCAN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= gwm_pkg::ST_IDLE;
         len_ff        <= '0;
         ovf_ff        <= 1'b0;
         sealed_ff     <= 1'b0;
         case_ff       <= 1'b0;
         act_ff        <= ActInit;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         len_ff        <= len_in;
         ovf_ff        <= ovf_in;
         sealed_ff     <= sealed_in;
         case_ff       <= case_in;
         act_ff        <= act_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      nxt_ff         <= nxt_in;
      p_ff           <= p_in;
      m_ff           <= m_in;
      q_ff           <= q_in;
      near_ff        <= near_in;
      have_ff        <= have_in;
      hit_ff         <= hit_in;
      esc_ff         <= esc_in;
      adv_ff         <= adv_in;
      c_ff           <= c_in;
      rsp_matched_ff <= rsp_matched_in;
      rsp_ovf_ff     <= rsp_ovf_in;
   end

endmodule

`default_nettype wire

### sv/gwm_checker.sv
// Port-level assertions for the glob wildcard matcher, with its bind.
`default_nettype none

module gwm_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       start,
   input wire logic       busy,
   input wire logic [1:0] req_type,
   input wire logic       rsp_strobe,
   input wire logic       rsp_matched,
   input wire logic       rsp_pattern_overflow
);

   // An overflowed pattern never reports a match
   a_ovf_no_match: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_matched && rsp_pattern_overflow))
      else $error("match reported with pattern overflow");

   // A result follows only a text-end transfer in the previous cycle
   a_rsp_after_end: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy && req_type == gwm_pkg::REQ_TEXT_END))
      else $error("result without a text-end transfer");

   // Pattern bytes are stored without leaving the block busy
   a_pat_byte_fast: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_type == gwm_pkg::REQ_PATTERN_BYTE) |=> !busy)
      else $error("pattern byte left the block busy");

   // Byte transfers never produce a result
   a_byte_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_type == gwm_pkg::REQ_PATTERN_BYTE ||
                          req_type == gwm_pkg::REQ_TEXT_BYTE)) |=> !rsp_strobe)
      else $error("result after a byte transfer");

endmodule

bind glob_wildcard_matcher gwm_checker u_gwm_checker (
   .clock                (clock),
   .reset                (reset),
   .start                (start),
   .busy                 (busy),
   .req_type             (req_type),
   .rsp_strobe           (rsp_strobe),
   .rsp_matched          (rsp_matched),
   .rsp_pattern_overflow (rsp_pattern_overflow)
);

`default_nettype wire
